// ===== hw/rtl/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg: shared constants for the SIP method classifier
// Method prefix table, SSDP signature, pre-filter constants and codes.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int unsigned PrefixCount = 11;
  localparam int unsigned PrefixMax   = 12;
  localparam int unsigned SsdpLen     = 17;
  localparam int unsigned PosW        = 7;
  localparam int unsigned KindW       = 4;
  localparam int unsigned MinLenW     = 7;

  localparam logic [PosW-1:0] POS_MAX       = 7'd127;
  localparam logic [MinLenW-1:0] MIN_LEN_RST = 7'd64;

  // slot of NOTIFY in the prefix table
  localparam int unsigned NotifyIdx = 5;

  localparam logic [KindW-1:0] KIND_NONE = 4'd0;

  // register word indexes on the config port
  localparam logic REG_MIN_LEN = 1'b0;

  localparam logic [31:0] FILTER_MASK_A = 32'h4941_5449;
  localparam logic [31:0] FILTER_MASK_B = 32'h5349_4220;
  localparam logic [63:0] FILTER_MAGIC  = 64'h7efe_fefe_7efe_feff;
  localparam logic [63:0] FILTER_HIGH   = 64'h8101_0101_8101_0100;

  // strings are right-justified: first char sits in the highest used byte
  localparam logic [PrefixMax*8-1:0] PREFIX_TEXT [PrefixCount] = '{
    "REGISTER", "INVITE", "OPTIONS :sip", "CANCEL", "INFO", "NOTIFY",
    "REPLY", "ACK", "BYE", "SUBSCRIBE", "PUBLISH"
  };
  localparam logic [3:0] PREFIX_LEN [PrefixCount] = '{
    4'd8, 4'd6, 4'd12, 4'd6, 4'd4, 4'd6, 4'd5, 4'd3, 4'd3, 4'd9, 4'd7
  };
  localparam logic [SsdpLen*8-1:0] SSDP_TEXT = "NOTIFY * HTTP/1.1";

  // one half of the pre-filter
  function automatic logic filter_hit(logic [31:0] word, logic [31:0] mask);
    logic [31:0] x;
    logic [63:0] r;
    x = word ^ mask;
    r = ({32'd0, x} + FILTER_MAGIC) ^ {32'd0, ~x};
    return (r & FILTER_HIGH) != 64'd0;
  endfunction

endpackage

// ===== hw/rtl/sip_method_classifier_core.sv =====
// ----------------------------------------------------------------------------
// sip_method_classifier_core: byte-stream SIP method classifier
// Classifies each payload at its last byte as a SIP message kind or 0.
// ----------------------------------------------------------------------------
// Channel  | Dir | Fields
// s_axis   | in  | tdata[7:0] payload_byte, tlast last_byte
// m_axis   | out | tdata[3:0] message_kind (bits 7:4 zero), one word per payload
// apb      | in  | word 0 (paddr 0): min_payload_length[6:0]
//
// One byte per cycle sustained while no last byte waits on a stalled result.
// A byte is taken into the input register; while it sits there the prefix
// compare, pre-filter and kind select run into the result register, which
// takes the kind of a last byte once that register is free.
// Reset clears all packet state, sets min_payload_length to 64, no sweep.
// A stalled result holds off a further last byte; other bytes keep flowing
// until that last byte reaches the input register.
// ----------------------------------------------------------------------------
module sip_method_classifier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // stream in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
  input  logic       s_axis_tlast,   // last_byte
  // stream out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] message_kind, [7:4] zero
  // config
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import smc_pkg::*;

  // config register
  logic [MinLenW-1:0] min_len_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_LEN);
  assign prdata = (paddr[2] == REG_MIN_LEN) ? {25'd0, min_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
    end else if (cfg_wr) begin
      min_len_q <= pwdata[MinLenW-1:0];
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic [KindW-1:0] kind_q;
  logic       out_free;
  logic       proc_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc_fire     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // packet state
  logic [PosW-1:0]        pos_q, pos_d, len;
  logic [31:0]            head_q, head_d;
  logic [PrefixCount-1:0] alive_q, alive_d;
  logic                   ssdp_q, ssdp_d;
  logic [KindW-1:0]       kind_d;

  always_comb begin
    logic [3:0] pidx;
    logic [4:0] sidx;
    logic       found;
    logic       pass;

    head_d  = head_q;
    alive_d = alive_q;
    ssdp_d  = ssdp_q;
    found   = 1'b0;
    kind_d  = KIND_NONE;

    case (pos_q)
      7'd0:    head_d[31:24] = in_byte_q;
      7'd1:    head_d[23:16] = in_byte_q;
      7'd2:    head_d[15:8]  = in_byte_q;
      7'd3:    head_d[7:0]   = in_byte_q;
      default: head_d = head_q;
    endcase

    for (int i = 0; i < PrefixCount; i++) begin
      pidx = 4'(PREFIX_LEN[i] - 4'd1 - pos_q[3:0]);
      if (pos_q < {3'd0, PREFIX_LEN[i]} && PREFIX_TEXT[i][pidx*8 +: 8] != in_byte_q) begin
        alive_d[i] = 1'b0;
      end
    end

    sidx = 5'(5'(SsdpLen) - 5'd1 - pos_q[4:0]);
    if (pos_q < 7'(SsdpLen) && SSDP_TEXT[sidx*8 +: 8] != in_byte_q) begin
      ssdp_d = 1'b0;
    end

    len = (pos_q == POS_MAX) ? POS_MAX : pos_q + 7'd1;

    pass = (len >= min_len_q) &&
           (filter_hit(head_d, FILTER_MASK_A) || filter_hit(head_d, FILTER_MASK_B));

    // first live prefix that fits wins
    for (int i = 0; i < PrefixCount; i++) begin
      if (!found && alive_d[i] && len >= {3'd0, PREFIX_LEN[i]}) begin
        found = 1'b1;
        if (i == NotifyIdx && ssdp_d && len >= 7'(SsdpLen)) begin
          kind_d = KIND_NONE;
        end else begin
          kind_d = KindW'(i + 1);
        end
      end
    end
    if (!pass) begin
      kind_d = KIND_NONE;
    end

    pos_d = len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      head_q  <= '0;
      alive_q <= '1;
      ssdp_q  <= 1'b1;
    end else if (proc_fire) begin
      if (in_last_q) begin
        pos_q   <= '0;
        head_q  <= '0;
        alive_q <= '1;
        ssdp_q  <= 1'b1;
      end else begin
        pos_q   <= pos_d;
        head_q  <= head_d;
        alive_q <= alive_d;
        ssdp_q  <= ssdp_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc_fire && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && in_last_q) begin
      kind_q <= kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, kind_q};

  // checks
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> kind_q <= 4'd11)
    else $error("message kind out of range");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && in_last_q |=> pos_q == '0 && alive_q == '1 && ssdp_q)
    else $error("packet state not cleared after last byte");

  a_pos_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && !in_last_q |=> pos_q != '0)
    else $error("byte position did not advance");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_fire && in_last_q))
    else $error("result without a processed last byte");

endmodule
